// ===== hw/rtl/strided_interval_set_membership_defines.svh =====
// Assertion macros shared by the strided interval set membership RTL.
`ifndef STRIDED_INTERVAL_SET_MEMBERSHIP_DEFINES_SVH
`define STRIDED_INTERVAL_SET_MEMBERSHIP_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define SISM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SISM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SISM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SISM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/sism_pkg.sv =====
// Package with types, codes and constants of the strided interval set membership block.
`timescale 1ns / 1ps

package sism_pkg;

  // Default table depth.
  localparam int MaxEntriesDef = 16;

  // Width of values, bounds and steps.
  localparam int DataW = 16;

  // Configuration port geometry.
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_VALUE_FLOOR = 2'd0;
  localparam logic [1:0] REG_VALUE_CEIL  = 2'd1;
  localparam logic [1:0] REG_ALL_BUT     = 2'd2;
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd3;

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Load status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD     = 2'd1;
  localparam logic [1:0] STAT_LIMITS  = 2'd2;
  localparam logic [1:0] STAT_OVERLAP = 2'd3;

  // One request beat.
  typedef struct packed {
    logic             cmd;
    logic [3:0]       entry_index;
    logic [DataW-1:0] range_low;
    logic [DataW-1:0] range_high;
    logic [DataW-1:0] stride;
    logic [DataW-1:0] probe_value;
  } sism_req_t;

  // One response beat.
  typedef struct packed {
    logic       member;
    logic [1:0] load_status;
  } sism_rsp_t;

  // One stored table entry: first member, last member and step.
  typedef struct packed {
    logic [DataW-1:0] lo;
    logic [DataW-1:0] last;
    logic [DataW-1:0] st;
  } sism_entry_t;

endpackage

// ===== hw/rtl/sism_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
`timescale 1ns / 1ps

interface sism_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== hw/rtl/strided_interval_set_membership.sv =====
// Strided interval set membership: sorted table of strided sub-ranges with load checks and queries.
`timescale 1ns / 1ps
`include "strided_interval_set_membership_defines.svh"

// The block works on one request at a time. A load with bad fields or limits
// is answered straight from idle, one that overlaps the previous entry after
// a read of that entry, and one that is stored after its last member is
// found with a 16-step restoring remainder unit; a load at slot zero skips
// the read of the previous entry. A query makes at most two reads of the
// table memory for the span check, one read per binary-search step, one read
// of the selected entry and 16 steps of the same remainder unit for the
// stride test; a query outside the span or on an empty set is shorter.
// A new request is taken once the previous result sits in the output
// register, even while that result still waits to be taken. The table
// memory has no reset and needs no clearing pass.
module strided_interval_set_membership
  import sism_pkg::*;
#(
  parameter int MAX_ENTRIES = MaxEntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sism_stream_if.sink       req_i,
  sism_stream_if.source     rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW = ($clog2(MAX_ENTRIES + 1) > 5) ? $clog2(MAX_ENTRIES + 1) : 5;
  localparam int ModCntW = $clog2(DataW);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LPREV  = 4'd1;
  localparam logic [3:0] ST_QFIRST = 4'd2;
  localparam logic [3:0] ST_QLAST  = 4'd3;
  localparam logic [3:0] ST_SRCH   = 4'd4;
  localparam logic [3:0] ST_QFINAL = 4'd5;
  localparam logic [3:0] ST_MOD    = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;

  // Configuration registers.
  logic [DataW-1:0] value_floor_q;
  logic [DataW:0]   value_ceil_q;
  logic             all_but_q;
  logic [4:0]       entry_count_q;
  logic             cfg_wr;

  // Control state.
  logic [3:0]         state_q, state_d;
  logic [IdxW-1:0]    l_q, l_d, r_q, r_d, m_q, m_d;
  logic [ModCntW-1:0] cnt_q, cnt_d;
  logic               rsp_valid_q, rsp_valid_d;

  // Datapath state.
  sism_req_t        item_q;
  sism_entry_t      rdata_q;
  sism_entry_t      entry_mem_q [MAX_ENTRIES];
  logic [DataW-1:0] rem_q, dvd_q, div_q;
  logic             mod_load_q;
  logic             res_member_q, res_member_d;
  logic [1:0]       res_status_q, res_status_d;
  sism_rsp_t        rsp_data_q;

  // Combinational control.
  logic              accept;
  logic [CntW-1:0]   n_c;
  logic [CntW-1:0]   idx_ext;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              mem_we;
  sism_entry_t       wdata;
  logic              mod_start;
  logic              mod_load_c;
  logic [DataW-1:0]  mod_dvd_c, mod_div_c;
  logic              fin_query;
  logic              raw_c;
  logic [DataW:0]    shifted;
  logic              fits;
  logic [DataW-1:0]  rem_next;
  logic [IdxW-1:0]   l_n, r_n, m_n;
  logic [IdxW:0]     mid_sum;
  logic              hit;
  logic [DataW-1:0]  v;
  sism_req_t         rq;

  // APB-style configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_VALUE_FLOOR: prdata = PdataW'(value_floor_q);
      REG_VALUE_CEIL:  prdata = PdataW'(value_ceil_q);
      REG_ALL_BUT:     prdata = PdataW'(all_but_q);
      REG_ENTRY_COUNT: prdata = PdataW'(entry_count_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_floor_q <= '0;
      value_ceil_q  <= (DataW + 1)'(1 << DataW);
      all_but_q     <= 1'b0;
      entry_count_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_VALUE_FLOOR: value_floor_q <= pwdata[DataW-1:0];
        REG_VALUE_CEIL:  value_ceil_q  <= pwdata[DataW:0];
        REG_ALL_BUT:     all_but_q     <= pwdata[0];
        REG_ENTRY_COUNT: entry_count_q <= pwdata[4:0];
        default:         ;
      endcase
    end
  end

  // Handshake and derived values. In idle the probe value comes straight
  // from the incoming beat, since the item register is loaded at the same edge.
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;
  assign rq          = req_i.data;
  assign v           = (state_q == ST_IDLE) ? rq.probe_value : item_q.probe_value;
  assign n_c         = (CntW'(entry_count_q) > CntW'(MAX_ENTRIES)) ? CntW'(MAX_ENTRIES)
                                                                 : CntW'(entry_count_q);
  assign idx_ext     = CntW'(item_q.entry_index);

  // One restoring remainder step.
  assign shifted  = {rem_q, dvd_q[DataW-1]};
  assign fits     = shifted >= {1'b0, div_q};
  assign rem_next = fits ? DataW'(shifted - {1'b0, div_q}) : shifted[DataW-1:0];

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    l_d          = l_q;
    r_d          = r_q;
    m_d          = m_q;
    cnt_d        = cnt_q;
    res_member_d = res_member_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    mem_we       = 1'b0;
    wdata        = '{lo: item_q.range_low,
                     last: DataW'(item_q.range_high - rem_next),
                     st: item_q.stride};
    mod_start    = 1'b0;
    mod_load_c   = 1'b0;
    mod_dvd_c    = '0;
    mod_div_c    = '0;
    fin_query    = 1'b0;
    raw_c        = 1'b0;
    l_n          = l_q;
    r_n          = r_q;
    m_n          = m_q;
    mid_sum      = '0;
    hit          = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (rq.cmd == CMD_LOAD) begin
            if ((rq.range_low > rq.range_high) || (rq.stride == '0)) begin
              res_member_d = 1'b0;
              res_status_d = STAT_BAD;
              state_d      = ST_EMIT;
            end else if ((rq.range_low < value_floor_q) ||
                         ({1'b0, rq.range_high} >= value_ceil_q) ||
                         (CntW'(rq.entry_index) >= CntW'(MAX_ENTRIES))) begin
              res_member_d = 1'b0;
              res_status_d = STAT_LIMITS;
              state_d      = ST_EMIT;
            end else if (rq.entry_index != '0) begin
              // Fetch the previous entry for the overlap check.
              rd_en   = 1'b1;
              rd_addr = IdxW'(CntW'(rq.entry_index) - CntW'(1));
              state_d = ST_LPREV;
            end else begin
              mod_start  = 1'b1;
              mod_load_c = 1'b1;
              mod_dvd_c  = DataW'(rq.range_high - rq.range_low);
              mod_div_c  = rq.stride;
              cnt_d      = '0;
              state_d    = ST_MOD;
            end
          end else begin
            if (n_c == '0) begin
              fin_query = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_QFIRST;
            end
          end
        end
      end

      ST_LPREV: begin
        if (rdata_q.last >= item_q.range_low) begin
          res_member_d = 1'b0;
          res_status_d = STAT_OVERLAP;
          state_d      = ST_EMIT;
        end else begin
          mod_start  = 1'b1;
          mod_load_c = 1'b1;
          mod_dvd_c  = DataW'(item_q.range_high - item_q.range_low);
          mod_div_c  = item_q.stride;
          cnt_d      = '0;
          state_d    = ST_MOD;
        end
      end

      ST_QFIRST: begin
        // Below the first entry means not in the table.
        if (v < rdata_q.lo) begin
          fin_query = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(n_c - CntW'(1));
          l_d     = '0;
          r_d     = IdxW'(n_c - CntW'(1));
          state_d = ST_QLAST;
        end
      end

      ST_QLAST: begin
        // Above the last entry's last member means not in the table.
        if (v > rdata_q.last) begin
          fin_query = 1'b1;
        end else if (l_q < r_q) begin
          mid_sum = {1'b0, l_q} + {1'b0, r_q} + (IdxW + 1)'(1);
          m_n     = mid_sum[IdxW:1];
          m_d     = m_n;
          rd_en   = 1'b1;
          rd_addr = m_n;
          state_d = ST_SRCH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = l_q;
          state_d = ST_QFINAL;
        end
      end

      ST_SRCH: begin
        // One binary-search step on the lower bound of the probed entry.
        if (v == rdata_q.lo) begin
          l_n = m_q;
          hit = 1'b1;
        end else if (v < rdata_q.lo) begin
          r_n = m_q - IdxW'(1);
        end else begin
          l_n = m_q;
        end
        l_d     = l_n;
        r_d     = r_n;
        mid_sum = {1'b0, l_n} + {1'b0, r_n} + (IdxW + 1)'(1);
        rd_en   = 1'b1;
        if (!hit && (l_n < r_n)) begin
          m_n     = mid_sum[IdxW:1];
          m_d     = m_n;
          rd_addr = m_n;
        end else begin
          rd_addr = l_n;
          state_d = ST_QFINAL;
        end
      end

      ST_QFINAL: begin
        if ((v < rdata_q.lo) || (v > rdata_q.last)) begin
          fin_query = 1'b1;
        end else if (rdata_q.st == '0) begin
          fin_query = 1'b1;
          raw_c     = (v == rdata_q.lo);
        end else begin
          mod_start = 1'b1;
          mod_dvd_c = DataW'(v - rdata_q.lo);
          mod_div_c = rdata_q.st;
          cnt_d     = '0;
          state_d   = ST_MOD;
        end
      end

      ST_MOD: begin
        cnt_d = cnt_q + ModCntW'(1);
        if (cnt_q == ModCntW'(DataW - 1)) begin
          if (mod_load_q) begin
            // Store the entry with its last member.
            mem_we       = 1'b1;
            res_member_d = 1'b0;
            res_status_d = STAT_OK;
            state_d      = ST_EMIT;
          end else begin
            fin_query = 1'b1;
            raw_c     = (rem_next == '0);
          end
        end
      end

      ST_EMIT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Final answer of a query, with the complement mode applied.
    if (fin_query) begin
      res_member_d = all_but_q ? ((value_floor_q <= v) && ({1'b0, v} < value_ceil_q) && !raw_c)
                               : raw_c;
      res_status_d = STAT_OK;
      state_d      = ST_EMIT;
    end
  end

  // Output register valid.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if ((state_q == ST_EMIT) && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      l_q         <= '0;
      r_q         <= '0;
      m_q         <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      l_q         <= l_d;
      r_q         <= r_d;
      m_q         <= m_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= rq;
    end
    res_member_q <= res_member_d;
    res_status_q <= res_status_d;
    if ((state_q == ST_EMIT) && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_data_q <= '{member: res_member_q, load_status: res_status_q};
    end
    if (mod_start) begin
      rem_q      <= '0;
      dvd_q      <= mod_dvd_c;
      div_q      <= mod_div_c;
      mod_load_q <= mod_load_c;
    end else if (state_q == ST_MOD) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[DataW-2:0], 1'b0};
    end
  end

  // Table memory: one write and one registered read per cycle. Only one
  // access of an item is in flight at a time, so a write never meets a read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[IdxW'(idx_ext)] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= entry_mem_q[rd_addr];
    end
  end

  // Checks.
  `SISM_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> !req_i.ready,
               "request taken while the previous one is still in work")
  `SISM_ASSERT(a_rsp_kind, clk_i, rst_ni,
               rsp_o.valid |-> (!rsp_o.data.member || (rsp_o.data.load_status == STAT_OK)),
               "response carries both a member flag and a load error")
  `SISM_ASSERT(a_search_order, clk_i, rst_ni, (state_q == ST_SRCH) |-> (l_q < r_q),
               "binary search bounds crossed")
  `SISM_ASSERT_NEVER(a_rem_bound, clk_i, rst_ni,
                     (state_q == ST_MOD) && (div_q != '0) && (rem_q >= div_q),
                     "partial remainder reached the divisor")

endmodule
